/* hdl/smsu_pkg.sv */
// Package for the SMBIOS system UUID extractor.
// Holds widths, phase codes, parse constants and the result record.
// No dependencies.
package smsu_pkg;

  // Width of the table byte counter and saturation limit of the table length
  localparam int OFFSET_BITS = 32;
  localparam int OFF_W       = OFFSET_BITS;
  // Table length field in the header is four bytes
  localparam int SIZE_W      = 32;
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'((64'd1 << OFFSET_BITS) - 64'd1);

  localparam int BYTE_W = 8;
  localparam int UUID_W = 128;
  localparam int HALF_W = 64;

  // Parser phase codes
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_HEADER  = 3'd0;
  localparam logic [PH_W-1:0] PH_TYPE    = 3'd1;
  localparam logic [PH_W-1:0] PH_LENGTH  = 3'd2;
  localparam logic [PH_W-1:0] PH_AREA    = 3'd3;
  localparam logic [PH_W-1:0] PH_STRINGS = 3'd4;
  localparam logic [PH_W-1:0] PH_DONE    = 3'd5;

  // Structure parsing constants
  localparam logic [BYTE_W-1:0] UUID_TYPE         = 8'h01;
  localparam logic [BYTE_W-1:0] UUID_MIN_LEN      = 8'h19;
  localparam logic [BYTE_W-1:0] MIN_STRUCT_LEN    = 8'h04;
  localparam logic [BYTE_W-1:0] HEADER_LEN        = 8'h08;
  localparam logic [BYTE_W-1:0] SIZE_FIELD_START  = 8'h04;
  localparam logic [BYTE_W-1:0] TARGET_AREA_BYTES = 8'd22;
  localparam logic [BYTE_W-1:0] UUID_BYTES        = 8'd16;
  // Type and length bytes are part of the formatted area
  localparam logic [BYTE_W-1:0] TYPE_LEN_BYTES    = 8'd2;

  // One result record
  typedef struct packed {
    logic              found;
    logic [HALF_W-1:0] uuid_upper;
    logic [HALF_W-1:0] uuid_lower;
  } res_t;

endpackage

/* hdl/smsu_if.sv */
// Channel interfaces for the SMBIOS system UUID extractor.
// Input channel carries buffer bytes, output channel carries results.
// No dependencies.
interface smsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface smsu_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [63:0] uuid_upper;
  logic [63:0] uuid_lower;

  modport source (output valid, output found, output uuid_upper, output uuid_lower,
                  input ready);
  modport sink   (input valid, input found, input uuid_upper, input uuid_lower,
                  output ready);
endinterface

/* hdl/smbios_system_uuid_extractor.sv */
// Top level of the SMBIOS system UUID extractor.
// Depends on smsu_pkg, smsu_if (smsu_in_if, smsu_out_if) and smsu_parser.
//
// Usage:
//   in_i  carries the raw SMBIOS buffer, one byte per transfer, from offset
//         zero; last_byte marks the final byte of a buffer.
//   out_o carries at most one result per buffer: found with the 16 UUID bytes
//         (byte 0 in the top of uuid_upper), or found = 0 with zero UUID.
//   The first type-1 structure with length >= 0x19 supplies the UUID; table
//   end, a remainder under four bytes or buffer end gives not-found.
// Timing:
//   One byte per cycle sustained while results on out_o are taken. A byte is
//   held in the input register, is parsed there by the state logic and its
//   result lands in the result register, from which it is offered on out_o.
// Reset:
//   rst_ni clears the valid flags of both registers and returns the parser to the header phase.
//   After the final byte of a buffer the parser re-arms the same way.
// Back-pressure:
//   While a result waits on out_o, one more byte is still taken into the input
//   register; in_i.ready then drops until the result is transferred.
module smbios_system_uuid_extractor (
  input  logic              clk_i,
  input  logic              rst_ni,
  smsu_in_if.sink           in_i,
  smsu_out_if.source        out_o
);
  import smsu_pkg::*;

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic              step;
  logic              emit;
  res_t              res;

  // Parse a held byte once the result register has room
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  smsu_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_data_q),
    .last_byte_i (in_last_q),
    .emit_o      (emit),
    .result_o    (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = out_res_q.found;
  assign out_o.uuid_upper = out_res_q.uuid_upper;
  assign out_o.uuid_lower = out_res_q.uuid_lower;

endmodule

/* hdl/smsu_parser.sv */
// Byte-wise SMBIOS table walker: holds the parse state, advances it by one
// byte per step and flags the result that a byte completes.
// Depends on smsu_pkg.
module smsu_parser (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic [smsu_pkg::BYTE_W-1:0]          data_byte_i,
  input  logic                                 last_byte_i,
  output logic                                 emit_o,
  output smsu_pkg::res_t                       result_o
);
  import smsu_pkg::*;

  logic [PH_W-1:0]   phase_q, phase_d;
  logic [OFF_W-1:0]  offset_q, offset_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [BYTE_W-1:0] area_q, area_d;
  logic              target_q, target_d;
  logic              prev_zero_q, prev_zero_d;
  logic [UUID_W-1:0] uuid_q, uuid_d;

  logic [OFF_W-1:0]  off_inc;
  logic [SIZE_W-1:0] hdr_size;
  logic [SIZE_W-1:0] sat_size;
  logic [BYTE_W-1:0] area_dec;
  logic [BYTE_W-1:0] len_eff;
  logic [UUID_W-1:0] uuid_shift;
  logic              in_table;
  logic              emit;
  logic              hit;

  // Shared arithmetic
  assign off_inc  = offset_q + OFF_W'(1);
  assign hdr_size = (offset_q >= OFF_W'(SIZE_FIELD_START)) ?
                    {data_byte_i, size_q[SIZE_W-1:BYTE_W]} : size_q;
  assign sat_size = ((hdr_size >> OFFSET_BITS) != '0) ? SIZE_MAX : hdr_size;
  assign area_dec = (area_q != '0) ? area_q - 8'd1 : '0;
  assign len_eff  = (data_byte_i < MIN_STRUCT_LEN) ? MIN_STRUCT_LEN : data_byte_i;
  assign in_table = (phase_q != PH_HEADER) && (phase_q != PH_DONE);
  // UUID with the current byte shifted in
  assign uuid_shift = {uuid_q[UUID_W-BYTE_W-1:0], data_byte_i};

  // Next-state logic for one byte
  always_comb begin
    phase_d     = phase_q;
    offset_d    = offset_q;
    size_d      = size_q;
    area_d      = area_q;
    target_d    = target_q;
    prev_zero_d = prev_zero_q;
    uuid_d      = uuid_q;
    emit        = 1'b0;
    hit         = 1'b0;

    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          size_d   = hdr_size;
          offset_d = off_inc;
          if (off_inc >= OFF_W'(HEADER_LEN)) begin
            size_d   = sat_size;
            offset_d = '0;
            phase_d  = PH_TYPE;
            if (sat_size < SIZE_W'(MIN_STRUCT_LEN)) emit = 1'b1;
          end
        end
        PH_TYPE: begin
          offset_d = off_inc;
          target_d = (data_byte_i == UUID_TYPE);
          phase_d  = PH_LENGTH;
        end
        PH_LENGTH: begin
          offset_d = off_inc;
          if (target_q && (data_byte_i >= UUID_MIN_LEN)) begin
            area_d = TARGET_AREA_BYTES;
            uuid_d = '0;
          end else begin
            target_d = 1'b0;
            area_d   = len_eff - TYPE_LEN_BYTES;
          end
          phase_d = PH_AREA;
        end
        PH_AREA: begin
          offset_d = off_inc;
          // UUID bytes are the last sixteen of the target's area
          if (target_q && (area_q <= UUID_BYTES)) begin
            uuid_d = uuid_shift;
          end
          area_d = area_dec;
          if (area_dec == '0) begin
            if (target_q) begin
              emit = 1'b1;
              hit  = 1'b1;
            end else begin
              phase_d     = PH_STRINGS;
              prev_zero_d = 1'b0;
            end
          end
        end
        PH_STRINGS: begin
          offset_d = off_inc;
          if ((data_byte_i == '0) && prev_zero_q) begin
            prev_zero_d = 1'b0;
            phase_d     = PH_TYPE;
            // Too few bytes left for another structure
            if (({1'b0, off_inc} + (OFF_W+1)'(MIN_STRUCT_LEN)) >
                {1'b0, size_q[OFF_W-1:0]}) begin
              emit = 1'b1;
            end
          end else begin
            prev_zero_d = (data_byte_i == '0);
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // Table end reached inside the walk
      if (in_table && !emit && (off_inc >= size_q[OFF_W-1:0])) emit = 1'b1;

      if (emit) phase_d = PH_DONE;

      // Buffer end: not-found if nothing given yet, then re-arm
      if (last_byte_i) begin
        if (!emit && (phase_q != PH_DONE)) emit = 1'b1;
        phase_d     = PH_HEADER;
        offset_d    = '0;
        size_d      = '0;
        area_d      = '0;
        target_d    = 1'b0;
        prev_zero_d = 1'b0;
        uuid_d      = '0;
      end
    end
  end

  // Result record for the byte being stepped; a hit always ends on a shifted byte
  always_comb begin
    emit_o              = emit;
    result_o.found      = hit;
    result_o.uuid_upper = hit ? uuid_shift[UUID_W-1:HALF_W] : '0;
    result_o.uuid_lower = hit ? uuid_shift[HALF_W-1:0] : '0;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      offset_q    <= '0;
      size_q      <= '0;
      area_q      <= '0;
      target_q    <= 1'b0;
      prev_zero_q <= 1'b0;
      uuid_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      offset_q    <= offset_d;
      size_q      <= size_d;
      area_q      <= area_d;
      target_q    <= target_d;
      prev_zero_q <= prev_zero_d;
      uuid_q      <= uuid_d;
    end
  end

endmodule

/* hdl/smsu_checker.sv */
// Port-level checks for the SMBIOS system UUID extractor, bound to the top.
// Depends on smbios_system_uuid_extractor and its interfaces.
module smsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        found_i,
  input logic [63:0] uuid_upper_i,
  input logic [63:0] uuid_lower_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(found_i) && $stable(uuid_upper_i) && $stable(uuid_lower_i))
    else $error("result payload changed while stalled");

  // Not-found results carry a zero UUID
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> (uuid_upper_i == '0) && (uuid_lower_i == '0))
    else $error("not-found result with nonzero UUID");

  // With the result stalled, one held byte fills the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i && in_valid_i && in_ready_i) ##1 !out_ready_i
      |-> !in_ready_i)
    else $error("input taken beyond one byte while result stalled");

endmodule

bind smbios_system_uuid_extractor smsu_checker u_smsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .found_i      (out_o.found),
  .uuid_upper_i (out_o.uuid_upper),
  .uuid_lower_i (out_o.uuid_lower)
);
